FILE: rtl/core/ffha_pkg.sv
// shared types, codes and constants of the first-fit heap allocator
package ffha_pkg;

  localparam int ADDR_W = 32;
  localparam int OFF_W  = 26;
  localparam int STAT_W = 2;
  localparam int CMD_W  = 5;
  localparam int PADDR_W = 3;

  localparam int HEAD_SLOT = 0;
  localparam int TAIL_SLOT = 1;

  localparam logic [ADDR_W-1:0] RESET_BASE = 32'h0400_0000;
  localparam logic [OFF_W-1:0]  RESET_SIZE = 26'h200_0000;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_NOP       = 5'd0;
  localparam cmd_t CMD_INIT0     = 5'd1;
  localparam cmd_t CMD_INIT1     = 5'd2;
  localparam cmd_t CMD_ACCEPT    = 5'd3;
  localparam cmd_t CMD_AWALK_A   = 5'd4;
  localparam cmd_t CMD_AWALK_B   = 5'd5;
  localparam cmd_t CMD_ASPLIT1   = 5'd6;
  localparam cmd_t CMD_ASPLIT2   = 5'd7;
  localparam cmd_t CMD_AMARK     = 5'd8;
  localparam cmd_t CMD_FWALK     = 5'd9;
  localparam cmd_t CMD_FMERGE0   = 5'd10;
  localparam cmd_t CMD_FMERGE1   = 5'd11;
  localparam cmd_t CMD_FMERGE2   = 5'd12;
  localparam cmd_t CMD_FMERGE3   = 5'd13;
  localparam cmd_t CMD_PUT_ALLOC = 5'd14;
  localparam cmd_t CMD_PUT_OOM   = 5'd15;
  localparam cmd_t CMD_PUT_BAD   = 5'd16;
  localparam cmd_t CMD_PUT_FREE  = 5'd17;

  typedef struct packed {
    logic tail;
    logic fit;
    logic split;
    logic match;
    logic req_free;
    logic out_free;
    logic cfg_wr;
  } stat_t;

endpackage

FILE: rtl/core/first_fit_heap_allocator_core.sv
// top level of the first-fit heap allocator: controller, datapath and ports
// First-fit heap allocator over an address-ordered table of up to MAX_BLOCKS
// block headers held in on-chip rams. One request (allocate or free) is in
// flight at a time; each gives exactly one result unless a register write
// cuts it short. An allocate walks the block chain through the AWALK_A and
// AWALK_B states for each block visited, then marks the fitting block or
// splits it (ASPLIT1, ASPLIT2). A free walks the chain in the FWALK state,
// then merges neighbors in FMERGE0 to FMERGE3. The walk is bound by the
// ram read latency on the chained next links. After reset or any register
// write the table is rebuilt (INIT0, INIT1), during which requests stall.
module first_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12,
  parameter int SPLIT_SLACK  = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffha_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [ffha_pkg::OFF_W-1:0]   request_size,
  input  logic [ffha_pkg::ADDR_W-1:0]  user_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]  result_address,
  output logic [ffha_pkg::STAT_W-1:0]  status
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;

  assign pready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .stat(stat),
    .in_stall(in_stall),
    .cmd(cmd)
  );

  ffha_dp #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES),
    .SPLIT_SLACK(SPLIT_SLACK)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .stat(stat),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .req_type(req_type),
    .request_size(request_size),
    .user_address(user_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_address(result_address),
    .status(status)
  );

endmodule

FILE: rtl/core/ffha_ram.sv
// generic single-write, single-read ram with registered read data
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ffha_ctrl.sv
// controller state machine sequencing allocate and free requests
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ffha_pkg::stat_t stat,
  output logic            in_stall,
  output ffha_pkg::cmd_t  cmd
);

  localparam logic [4:0] S_INIT0     = 5'd0;
  localparam logic [4:0] S_INIT1     = 5'd1;
  localparam logic [4:0] S_IDLE      = 5'd2;
  localparam logic [4:0] S_AWA       = 5'd3;
  localparam logic [4:0] S_AWB       = 5'd4;
  localparam logic [4:0] S_SPL1      = 5'd5;
  localparam logic [4:0] S_SPL2      = 5'd6;
  localparam logic [4:0] S_MARK      = 5'd7;
  localparam logic [4:0] S_FW        = 5'd8;
  localparam logic [4:0] S_FM0       = 5'd9;
  localparam logic [4:0] S_FM1       = 5'd10;
  localparam logic [4:0] S_FM2       = 5'd11;
  localparam logic [4:0] S_FM3       = 5'd12;
  localparam logic [4:0] S_OUT_ALLOC = 5'd13;
  localparam logic [4:0] S_OUT_OOM   = 5'd14;
  localparam logic [4:0] S_OUT_BAD   = 5'd15;
  localparam logic [4:0] S_OUT_FREE  = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_stall = (state != S_IDLE) || stat.cfg_wr;

  always_comb begin
    state_next = state;
    cmd = ffha_pkg::CMD_NOP;
    unique case (state)
      S_INIT0: begin
        cmd = ffha_pkg::CMD_INIT0;
        state_next = S_INIT1;
      end
      S_INIT1: begin
        cmd = ffha_pkg::CMD_INIT1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = ffha_pkg::CMD_ACCEPT;
          state_next = stat.req_free ? S_FW : S_AWA;
        end
      end
      S_AWA: begin
        cmd = ffha_pkg::CMD_AWALK_A;
        state_next = stat.tail ? S_OUT_OOM : S_AWB;
      end
      S_AWB: begin
        cmd = ffha_pkg::CMD_AWALK_B;
        if (stat.fit) begin
          state_next = stat.split ? S_SPL1 : S_MARK;
        end else begin
          state_next = S_AWA;
        end
      end
      S_SPL1: begin
        cmd = ffha_pkg::CMD_ASPLIT1;
        state_next = S_SPL2;
      end
      S_SPL2: begin
        cmd = ffha_pkg::CMD_ASPLIT2;
        state_next = S_OUT_ALLOC;
      end
      S_MARK: begin
        cmd = ffha_pkg::CMD_AMARK;
        state_next = S_OUT_ALLOC;
      end
      S_FW: begin
        cmd = ffha_pkg::CMD_FWALK;
        if (stat.tail) begin
          state_next = S_OUT_BAD;
        end else if (stat.match) begin
          state_next = S_FM0;
        end
      end
      S_FM0: begin
        cmd = ffha_pkg::CMD_FMERGE0;
        state_next = S_FM1;
      end
      S_FM1: begin
        cmd = ffha_pkg::CMD_FMERGE1;
        state_next = S_FM2;
      end
      S_FM2: begin
        cmd = ffha_pkg::CMD_FMERGE2;
        state_next = S_FM3;
      end
      S_FM3: begin
        cmd = ffha_pkg::CMD_FMERGE3;
        state_next = S_OUT_FREE;
      end
      S_OUT_ALLOC: begin
        if (stat.out_free) begin
          cmd = ffha_pkg::CMD_PUT_ALLOC;
          state_next = S_IDLE;
        end
      end
      S_OUT_OOM: begin
        if (stat.out_free) begin
          cmd = ffha_pkg::CMD_PUT_OOM;
          state_next = S_IDLE;
        end
      end
      S_OUT_BAD: begin
        if (stat.out_free) begin
          cmd = ffha_pkg::CMD_PUT_BAD;
          state_next = S_IDLE;
        end
      end
      S_OUT_FREE: begin
        if (stat.out_free) begin
          cmd = ffha_pkg::CMD_PUT_FREE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT0;
      end
    endcase
    if (stat.cfg_wr) begin
      cmd = ffha_pkg::CMD_NOP;
      state_next = S_INIT0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/ffha_dp.sv
// datapath: block table rams, slot bookkeeping, config registers and result register
module ffha_dp #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12,
  parameter int SPLIT_SLACK  = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ffha_pkg::cmd_t                      cmd,
  output ffha_pkg::stat_t                     stat,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ffha_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  input  logic                                req_type,
  input  logic [ffha_pkg::OFF_W-1:0]          request_size,
  input  logic [ffha_pkg::ADDR_W-1:0]         user_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]         result_address,
  output logic [ffha_pkg::STAT_W-1:0]         status
);

  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int OW = ffha_pkg::OFF_W;
  localparam int AW = ffha_pkg::ADDR_W;
  localparam int EW = OW + 2;
  localparam logic [SW-1:0] HEAD = SW'(ffha_pkg::HEAD_SLOT);
  localparam logic [SW-1:0] TAIL = SW'(ffha_pkg::TAIL_SLOT);
  localparam logic [EW-1:0] HB_E = EW'(HEADER_BYTES);
  localparam logic [EW-1:0] SPL_E = EW'(HEADER_BYTES + HEADER_BYTES + SPLIT_SLACK);
  localparam logic [AW-1:0] HB_A = AW'(HEADER_BYTES);
  localparam logic [OW-1:0] HB_O = OW'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [MAX_BLOCKS-1:0] TAKEN_INIT =
    (MAX_BLOCKS'(1) << ffha_pkg::HEAD_SLOT) | (MAX_BLOCKS'(1) << ffha_pkg::TAIL_SLOT);

  logic [AW-1:0] heap_base;
  logic [OW-1:0] heap_size;

  logic [OW-1:0] want;
  logic [AW-1:0] target;
  logic [SW-1:0] cur;
  logic [OW-1:0] c_off;
  logic          c_free;
  logic [SW-1:0] c_next;
  logic [SW-1:0] c_prev;
  logic          n_free;
  logic [SW-1:0] n_next;
  logic          p_free;
  logic [EW-1:0] end_want;
  logic [EW-1:0] end_split;
  logic [SW-1:0] new_slot;
  logic [SW-1:0] free_slot;
  logic [SW-1:0] free_slot_next;
  logic [MAX_BLOCKS-1:0] taken;
  logic [CW-1:0] count;

  logic cfg_wr;
  logic put;
  logic merge_n;
  logic merge_p;
  logic [OW-1:0] tail_off;

  logic          off_we, free_we, next_we, prev_we;
  logic [SW-1:0] off_wa, free_wa, next_wa, prev_wa;
  logic [OW-1:0] off_wd;
  logic          free_wd;
  logic [SW-1:0] next_wd, prev_wd;
  logic [SW-1:0] off_ra, free_ra, next_ra, prev_ra;
  logic [OW-1:0] rd_off;
  logic          rd_free;
  logic [SW-1:0] rd_next, rd_prev;

  ffha_ram #(.WIDTH(OW), .DEPTH(MAX_BLOCKS)) u_off_ram (
    .clk(clk), .we(off_we), .waddr(off_wa), .wdata(off_wd), .raddr(off_ra), .rdata(rd_off)
  );
  ffha_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd), .raddr(free_ra),
    .rdata(rd_free)
  );
  ffha_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(next_ra),
    .rdata(rd_next)
  );
  ffha_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(prev_ra),
    .rdata(rd_prev)
  );

  assign cfg_wr = psel && penable && pwrite;
  assign tail_off = (heap_size >= HB_O) ? heap_size - HB_O : '0;
  assign merge_n = (c_next != TAIL) && (c_next != HEAD) && n_free;
  assign merge_p = (cur != HEAD) && p_free;
  assign put = (cmd == ffha_pkg::CMD_PUT_ALLOC) || (cmd == ffha_pkg::CMD_PUT_OOM) ||
               (cmd == ffha_pkg::CMD_PUT_BAD) || (cmd == ffha_pkg::CMD_PUT_FREE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == ffha_pkg::REG_SIZE) begin
      prdata = {{(32-OW){1'b0}}, heap_size};
    end else begin
      prdata = heap_base;
    end
  end

  always_comb begin
    stat.tail     = (cur == TAIL);
    stat.fit      = c_free && (({2'b00, rd_off} >= end_want) || (want == '0));
    stat.split    = stat.fit && ({2'b00, rd_off} > end_split) && (count < MAXC);
    stat.match    = ({{(AW-OW){1'b0}}, rd_off} == target);
    stat.req_free = (req_type == ffha_pkg::REQ_FREE);
    stat.out_free = !out_valid || !out_stall;
    stat.cfg_wr   = cfg_wr;
  end

  always_comb begin
    free_slot_next = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!taken[i]) begin
        free_slot_next = SW'(i);
      end
    end
  end

  always_comb begin
    off_we = 1'b0;  off_wa = cur;  off_wd = end_want[OW-1:0];
    free_we = 1'b0; free_wa = cur; free_wd = 1'b0;
    next_we = 1'b0; next_wa = cur; next_wd = new_slot;
    prev_we = 1'b0; prev_wa = cur; prev_wd = cur;
    off_ra = cur; free_ra = cur; next_ra = cur; prev_ra = cur;
    case (cmd)
      ffha_pkg::CMD_INIT0: begin
        off_we = 1'b1;  off_wa = HEAD;  off_wd = '0;
        free_we = 1'b1; free_wa = HEAD; free_wd = 1'b1;
        next_we = 1'b1; next_wa = HEAD; next_wd = TAIL;
        prev_we = 1'b1; prev_wa = HEAD; prev_wd = HEAD;
      end
      ffha_pkg::CMD_INIT1: begin
        off_we = 1'b1;  off_wa = TAIL;  off_wd = tail_off;
        free_we = 1'b1; free_wa = TAIL; free_wd = 1'b0;
        next_we = 1'b1; next_wa = TAIL; next_wd = TAIL;
        prev_we = 1'b1; prev_wa = TAIL; prev_wd = HEAD;
      end
      ffha_pkg::CMD_ACCEPT: begin
        off_ra = HEAD; free_ra = HEAD; next_ra = HEAD;
      end
      ffha_pkg::CMD_AWALK_A: begin
        off_ra = rd_next;
      end
      ffha_pkg::CMD_AWALK_B: begin
        off_ra = c_next; free_ra = c_next; next_ra = c_next;
      end
      ffha_pkg::CMD_ASPLIT1: begin
        off_we = 1'b1;  off_wa = free_slot;  off_wd = end_want[OW-1:0];
        free_we = 1'b1; free_wa = free_slot; free_wd = 1'b1;
        next_we = 1'b1; next_wa = free_slot; next_wd = c_next;
        prev_we = 1'b1; prev_wa = free_slot; prev_wd = cur;
      end
      ffha_pkg::CMD_ASPLIT2: begin
        prev_we = 1'b1; prev_wa = c_next; prev_wd = new_slot;
        next_we = 1'b1; next_wa = cur;    next_wd = new_slot;
        free_we = 1'b1; free_wa = cur;    free_wd = 1'b0;
      end
      ffha_pkg::CMD_AMARK: begin
        free_we = 1'b1; free_wa = cur; free_wd = 1'b0;
      end
      ffha_pkg::CMD_FWALK: begin
        off_ra = rd_next; next_ra = rd_next;
      end
      ffha_pkg::CMD_FMERGE0: begin
        free_we = 1'b1; free_wa = cur; free_wd = 1'b1;
        free_ra = c_next; next_ra = c_next; prev_ra = cur;
      end
      ffha_pkg::CMD_FMERGE1: begin
        free_ra = rd_prev;
      end
      ffha_pkg::CMD_FMERGE2: begin
        if (merge_n) begin
          next_we = 1'b1; next_wa = cur;    next_wd = n_next;
          prev_we = 1'b1; prev_wa = n_next; prev_wd = cur;
          free_we = 1'b1; free_wa = c_next; free_wd = 1'b0;
        end
      end
      ffha_pkg::CMD_FMERGE3: begin
        if (merge_p) begin
          next_we = 1'b1; next_wa = c_prev; next_wd = c_next;
          prev_we = 1'b1; prev_wa = c_next; prev_wd = c_prev;
          free_we = 1'b1; free_wa = cur;    free_wd = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= ffha_pkg::RESET_BASE;
      heap_size <= ffha_pkg::RESET_SIZE;
    end else if (cfg_wr) begin
      if (paddr[2] == ffha_pkg::REG_SIZE) begin
        heap_size <= pwdata[OW-1:0];
      end else begin
        heap_base <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
      count <= '0;
    end else begin
      case (cmd)
        ffha_pkg::CMD_INIT0: begin
          taken <= TAKEN_INIT;
          count <= CW'(2);
        end
        ffha_pkg::CMD_ASPLIT1: begin
          taken[free_slot] <= 1'b1;
          count <= count + CW'(1);
        end
        ffha_pkg::CMD_FMERGE2: begin
          if (merge_n) begin
            taken[c_next] <= 1'b0;
            count <= count - CW'(1);
          end
        end
        ffha_pkg::CMD_FMERGE3: begin
          if (merge_p) begin
            taken[cur] <= 1'b0;
            count <= count - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    free_slot <= free_slot_next;
    case (cmd)
      ffha_pkg::CMD_ACCEPT: begin
        want <= request_size;
        target <= user_address - heap_base - HB_A;
        cur <= HEAD;
      end
      ffha_pkg::CMD_AWALK_A: begin
        c_off <= rd_off;
        c_free <= rd_free;
        c_next <= rd_next;
        end_want <= {2'b00, rd_off} + {2'b00, want} + HB_E;
        end_split <= {2'b00, rd_off} + {2'b00, want} + SPL_E;
      end
      ffha_pkg::CMD_AWALK_B: begin
        if (!stat.fit) begin
          cur <= c_next;
        end
      end
      ffha_pkg::CMD_ASPLIT1: begin
        new_slot <= free_slot;
      end
      ffha_pkg::CMD_FWALK: begin
        if (!stat.tail) begin
          if (stat.match) begin
            c_next <= rd_next;
          end else begin
            cur <= rd_next;
          end
        end
      end
      ffha_pkg::CMD_FMERGE1: begin
        n_free <= rd_free;
        n_next <= rd_next;
        c_prev <= rd_prev;
      end
      ffha_pkg::CMD_FMERGE2: begin
        p_free <= rd_free;
        if (merge_n) begin
          c_next <= n_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      ffha_pkg::CMD_PUT_ALLOC: begin
        result_address <= heap_base + {{(AW-OW){1'b0}}, c_off} + HB_A;
        status <= ffha_pkg::STAT_DONE;
      end
      ffha_pkg::CMD_PUT_OOM: begin
        result_address <= '0;
        status <= ffha_pkg::STAT_OOM;
      end
      ffha_pkg::CMD_PUT_BAD: begin
        result_address <= '0;
        status <= ffha_pkg::STAT_BAD;
      end
      ffha_pkg::CMD_PUT_FREE: begin
        result_address <= '0;
        status <= ffha_pkg::STAT_DONE;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("block count above table size");
  a_count_taken: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> ($countones(taken) == 32'(count)))
    else $error("block count disagrees with occupied slots");
  a_ends_held: assert property (@(posedge clk) disable iff (rst)
    (cmd != ffha_pkg::CMD_INIT0) && $past(!rst) |-> (taken[HEAD] && taken[TAIL]))
    else $error("first block or sentinel slot released");
  a_put_room: assert property (@(posedge clk) disable iff (rst)
    put |-> (!out_valid || !out_stall))
    else $error("result loaded over an undelivered one");
`endif

endmodule
